### rtl/core/message_ring_queue_with_jam_defines.svh
// ----------------------------------------------------------------------------
// message ring queue assertion macros
// property wrappers used by the queue rtl; compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef MESSAGE_RING_QUEUE_WITH_JAM_DEFINES_SVH
`define MESSAGE_RING_QUEUE_WITH_JAM_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on i_clk, off during reset
`define MRQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrq assertion failed");
// next-cycle implication, clocked on i_clk, off during reset
`define MRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrq assertion failed");
`else
`define MRQ_ASSERT_NOW(label, ante, cons)
`define MRQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/mrq_pkg.sv
// ----------------------------------------------------------------------------
// message ring queue package
// command and status codes, payload structs and register map constants
// ----------------------------------------------------------------------------
package mrq_pkg;

    // width of the capacity register and of the message count
    localparam int CAP_W = 5;
    localparam int MSG_W = 32;

    // apb address width and register map
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_JAM  = 2'd1,
        CMD_RECV = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               command;
        logic [MSG_W-1:0]   message_in;
    } t_mrq_in;

    typedef struct packed {
        t_status            status;
        logic [MSG_W-1:0]   message_out;
        logic [CAP_W-1:0]   count_out;
    } t_mrq_out;

endpackage

### rtl/core/mrq_ram.sv
// ----------------------------------------------------------------------------
// mrq_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/message_ring_queue_with_jam.sv
// Result path: a command's result passes through the staging register and then
// the result register, and it waits in either while the result channel stalls.
// Throughput: one command per cycle while results are taken; the slot ram
// read of a receive is issued in the accept cycle and used by the staging stage.
// Reset: capacity becomes min(16, DEPTH), the queue is empty, head is zero.
// The slot ram is not cleared; only slots written by send or jam are read.
// ----------------------------------------------------------------------------
// message_ring_queue_with_jam
// circular message queue with tail send, head jam and head receive
// ----------------------------------------------------------------------------
`include "message_ring_queue_with_jam_defines.svh"

module message_ring_queue_with_jam #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mrq_pkg::t_mrq_in                  i_in,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mrq_pkg::t_mrq_out                 o_out,
    // apb configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mrq_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = mrq_pkg::CAP_W;
    localparam int SW      = ((AW > CW) ? AW : CW) + 1;
    localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
    localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

    // queue state
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_cap;

    // staging register between accept and result
    logic                   r_s1_valid;
    mrq_pkg::t_status       r_s1_status, n_status;
    logic [CW-1:0]          r_s1_count;
    logic                   r_s1_take, n_take;

    // result register
    logic                   r_out_valid;
    mrq_pkg::t_mrq_out      r_out;

    // ram controls
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr;
    logic [mrq_pkg::MSG_W-1:0] ram_rdata;

    logic                   in_acc, s1_adv, cfg_wr, full;
    logic [SW-1:0]          head_ext, cap_ext, tail_sum, head_inc;
    logic [AW-1:0]          tail_slot, jam_slot, next_head;
    logic [CW-1:0]          cap_wval, cap_new;

    // handshakes
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite
                        && (paddr[mrq_pkg::PADDR_W-1:2] == mrq_pkg::REG_CAPACITY);

    // apb read and clamp of written capacity
    assign pready   = 1'b1;
    assign prdata   = (paddr[mrq_pkg::PADDR_W-1:2] == mrq_pkg::REG_CAPACITY)
                      ? {{(32-CW){1'b0}}, r_cap} : 32'd0;
    assign cap_wval = pwdata[CW-1:0];

    always_comb begin
        if (cap_wval == '0) begin
            cap_new = CW'(1);
        end else if (cap_wval > CW'(CAP_MAX)) begin
            cap_new = CW'(CAP_MAX);
        end else begin
            cap_new = cap_wval;
        end
    end

    // slot addresses, all wrapped at capacity
    assign head_ext  = SW'(r_head);
    assign cap_ext   = SW'(r_cap);
    assign tail_sum  = head_ext + SW'(r_count);
    assign tail_slot = (tail_sum >= cap_ext) ? AW'(tail_sum - cap_ext) : AW'(tail_sum);
    assign jam_slot  = (r_head == '0) ? AW'(cap_ext - SW'(1)) : (r_head - AW'(1));
    assign head_inc  = head_ext + SW'(1);
    assign next_head = (head_inc == cap_ext) ? '0 : AW'(head_inc);
    assign full      = (r_count >= r_cap);

    // command decode
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_status  = mrq_pkg::ST_OK;
        n_take    = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = tail_slot;
        case (i_in.command)
            mrq_pkg::CMD_SEND: begin
                if (full) begin
                    n_status = mrq_pkg::ST_FULL;
                end else begin
                    ram_we  = in_acc;
                    n_count = r_count + CW'(1);
                end
            end
            mrq_pkg::CMD_JAM: begin
                if (full) begin
                    n_status = mrq_pkg::ST_FULL;
                end else begin
                    ram_we    = in_acc;
                    ram_waddr = jam_slot;
                    n_head    = jam_slot;
                    n_count   = r_count + CW'(1);
                end
            end
            mrq_pkg::CMD_RECV: begin
                if (r_count == '0) begin
                    n_status = mrq_pkg::ST_EMPTY;
                end else begin
                    ram_re  = in_acc;
                    n_take  = 1'b1;
                    n_head  = next_head;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // slot store
    mrq_ram #(
        .WIDTH (mrq_pkg::MSG_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.message_in),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // head, count and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_cap   <= CW'(CAP_RST);
        end else if (cfg_wr) begin
            r_head  <= '0;
            r_count <= '0;
            r_cap   <= cap_new;
        end else if (in_acc) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // staging register, waits for the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= n_status;
            r_s1_count  <= n_count;
            r_s1_take   <= n_take;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.status      <= r_s1_status;
            r_out.message_out <= r_s1_take ? ram_rdata : '0;
            r_out.count_out   <= r_s1_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks on queue bookkeeping
    `MRQ_ASSERT_NOW(a_count_in_cap, 1'b1, r_count <= r_cap)
    `MRQ_ASSERT_NOW(a_head_in_cap, 1'b1, head_ext < cap_ext)
    `MRQ_ASSERT_NOW(a_cap_nonzero, 1'b1, r_cap != '0)
    `MRQ_ASSERT_NEXT(a_recv_drops_one, in_acc && !cfg_wr && n_take, r_count == $past(n_count))

endmodule
